/* rtl/core/lstm_cell_state_update_unit_macros.svh */
// ----------------------------------------------------------------------------
// LSTM cell state update unit: assertion macros
// Shared concurrent assertion forms. All of them use clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef LSTM_CELL_STATE_UPDATE_UNIT_MACROS_SVH
`define LSTM_CELL_STATE_UPDATE_UNIT_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define LCSU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define LCSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lcsu_pkg.sv */
// ----------------------------------------------------------------------------
// LSTM cell state update unit: package
// Format constants and the tanh magnitude table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsu_pkg;

  localparam int ELEMENTS           = 4096;
  localparam int FRAC_BITS          = 12;
  localparam int TANH_TABLE_ENTRIES = 256;

  localparam int ADDR_W    = $clog2(ELEMENTS);
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 16;
  localparam int CONT_W    = 13;
  localparam int CONT_ONE  = 4096;
  localparam int HID_W     = 14;
  localparam int GATE_W    = FRAC_BITS + 1;
  localparam int ACT_W     = FRAC_BITS + 2;
  localparam int LUT_IDX_W = $clog2(TANH_TABLE_ENTRIES);
  localparam int LUT_SHIFT = 15 - LUT_IDX_W;

  // Half the width of one magnitude bin, as a real value.
  localparam real TANH_HALF_BIN = (2.0 ** (14 - FRAC_BITS)) / real'(TANH_TABLE_ENTRIES);

  typedef logic [FRAC_BITS:0] tanh_lut_t [TANH_TABLE_ENTRIES];

  // Entry k holds tanh at the midpoint of magnitude bin k, rounded to FRAC_BITS.
  function automatic tanh_lut_t build_tanh_lut();
    tanh_lut_t lut;
    real       t;
    real       v;
    for (int k = 0; k < TANH_TABLE_ENTRIES; k++) begin
      t      = real'(2 * k + 1) * TANH_HALF_BIN;
      v      = $floor($tanh(t) * (2.0 ** FRAC_BITS) + 0.5);
      lut[k] = (FRAC_BITS + 1)'($rtoi(v));
    end
    return lut;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_tanh_lut();

endpackage

`default_nettype wire

/* rtl/core/lstm_cell_state_update_unit.sv */
// ----------------------------------------------------------------------------
// LSTM cell state update unit
// Elementwise LSTM step with the cell state held in an on-chip memory.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid_i / in_ready_o), one element's
// eight gate pre-activations, continuation factor and optional initial cell
// value each. Results leave on the output channel (out_valid_o / out_ready_i)
// in input order: the element index, the new cell value and the new hidden
// value.
// One item is taken per cycle while the skid register is empty and the
// memory clear is done. Each item passes through six stages: the input
// register, the gate sums, the activation tables, the gate products, the cell
// update with its memory read-modify-write, and the hidden product.
// Back-to-back items to the same element are served by forwarding the freshly
// written cell value. A skid register behind the last stage takes the result
// when the receiver stalls; while it is full, the whole pipeline holds. After
// reset the cell memory is cleared one entry per cycle, all 4096 entries,
// during which in_ready_o stays low. cont_enable may be written at any time
// through cfg_we_i; it resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lstm_cell_state_update_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lcsu_pkg::IDX_W-1:0]           element_index_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   x_input_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   x_output_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   x_forget_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   x_cell_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   h_input_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   h_output_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   h_forget_gate_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   h_cell_gate_i,
  input  logic [lcsu_pkg::CONT_W-1:0]          cont_factor_i,
  input  logic                                 load_initial_i,
  input  logic signed [lcsu_pkg::DATA_W-1:0]   initial_cell_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lcsu_pkg::IDX_W-1:0]           out_index_o,
  output logic signed [lcsu_pkg::DATA_W-1:0]   new_cell_o,
  output logic signed [lcsu_pkg::HID_W-1:0]    new_hidden_o
);
  import lcsu_pkg::*;

  `include "lstm_cell_state_update_unit_macros.svh"

  // Control
  logic              cont_enable_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_q;
  logic              v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, sk_v_q;
  logic              adv;
  logic              in_fire;

  // Stage 1
  logic [IDX_W-1:0]         idx1_q;
  logic signed [DATA_W-1:0] x1_q [4];
  logic signed [DATA_W-1:0] h1_q [4];
  logic [CONT_W-1:0]        cont1_q;
  logic                     load1_q;
  logic signed [DATA_W-1:0] init1_q;
  logic [CONT_W-1:0]        cont_d;

  // Stage 2
  logic [IDX_W-1:0]         idx2_q;
  logic signed [DATA_W-1:0] g2_q [4];
  logic signed [DATA_W-1:0] g2_d [4];
  logic [CONT_W-1:0]        cont2_q;
  logic                     load2_q;
  logic signed [DATA_W-1:0] init2_q;

  // Stage 3
  logic [IDX_W-1:0]         idx3_q;
  logic [GATE_W-1:0]        gi3_q, go3_q, gf3_q;
  logic signed [ACT_W-1:0]  gc3_q;
  logic [CONT_W-1:0]        cont3_q;
  logic                     load3_q;
  logic signed [DATA_W-1:0] init3_q;
  logic signed [ACT_W-1:0]  th_i, th_o, th_f, th_c;
  logic signed [DATA_W-1:0] half_i, half_o, half_f;
  logic [GATE_W-1:0]        gi_d, go_d, gf_d;
  logic signed [GATE_W+ACT_W:0] ig_prod;

  // Stage 4
  logic [IDX_W-1:0]         idx4_q;
  logic [2*CONT_W-1:0]      cf4_q;
  logic signed [GATE_W+ACT_W:0] ig4_q;
  logic [GATE_W-1:0]        go4_q;
  logic                     load4_q;
  logic signed [DATA_W-1:0] init4_q;
  logic signed [DATA_W-1:0] rd_q;

  // Stage 5
  logic [IDX_W-1:0]         idx5_q;
  logic signed [DATA_W-1:0] c5_q;
  logic signed [DATA_W-1:0] c5_d;
  logic [GATE_W-1:0]        go5_q;
  logic signed [DATA_W-1:0] c_old;
  logic signed [42:0]       cf_prod;
  logic signed [43:0]       acc;
  logic signed [43:0]       acc_rnd;
  logic signed [19:0]       acc_sh;
  logic signed [ACT_W-1:0]  th_c5;

  // Stage 6 and skid
  logic [IDX_W-1:0]         idx6_q, idx_sk_q;
  logic signed [DATA_W-1:0] c6_q, c_sk_q;
  logic signed [HID_W-1:0]  h6_q, h_sk_q;
  logic signed [HID_W-1:0]  h6_d;
  logic signed [2*ACT_W-1:0] hp;
  logic signed [2*ACT_W-1:0] hp_rnd;

  // Memory
  logic signed [DATA_W-1:0] cell_mem_q [ELEMENTS];
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;

  assign adv        = !sk_v_q;
  assign in_ready_o = adv && !clr_busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (!cont_enable_q) begin
      cont_d = CONT_W'(CONT_ONE);
    end else if (cont_factor_i > CONT_W'(CONT_ONE)) begin
      cont_d = CONT_W'(CONT_ONE);
    end else begin
      cont_d = cont_factor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_enable_q <= 1'b0;
      clr_busy_q    <= 1'b1;
      clr_q         <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      v5_q          <= 1'b0;
      v6_q          <= 1'b0;
      sk_v_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cont_enable_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == ADDR_W'(ELEMENTS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv) begin
        v1_q <= in_fire;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
      end
      if (sk_v_q) begin
        if (out_ready_i) begin
          sk_v_q <= 1'b0;
        end
      end else if (v6_q && !out_ready_i) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  // Gate sums: scaled hidden part, rounded half up, added and saturated.
  always_comb begin
    logic signed [29:0] prod;
    logic signed [29:0] rnd;
    logic signed [17:0] hs;
    logic signed [17:0] sum;
    for (int k = 0; k < 4; k++) begin
      prod = $signed({1'b0, cont1_q}) * h1_q[k];
      rnd  = prod + 30'sd2048;
      hs   = 18'(rnd >>> 12);
      sum  = 18'(x1_q[k]) + hs;
      if (sum > 18'sd32767) begin
        g2_d[k] = 16'sh7fff;
      end else if (sum < -18'sd32768) begin
        g2_d[k] = -16'sh8000;
      end else begin
        g2_d[k] = 16'(sum);
      end
    end
  end

  assign half_i = g2_q[0] >>> 1;
  assign half_o = g2_q[1] >>> 1;
  assign half_f = g2_q[2] >>> 1;

  lcsu_tanh u_tanh_i (.x_i(half_i),  .y_o(th_i));
  lcsu_tanh u_tanh_o (.x_i(half_o),  .y_o(th_o));
  lcsu_tanh u_tanh_f (.x_i(half_f),  .y_o(th_f));
  lcsu_tanh u_tanh_c (.x_i(g2_q[3]), .y_o(th_c));
  lcsu_tanh u_tanh_h (.x_i(c5_q),    .y_o(th_c5));

  always_comb begin
    logic signed [ACT_W:0] si, so, sf;
    si   = (ACT_W + 1)'(th_i) + (ACT_W + 1)'((1 << FRAC_BITS) + 1);
    so   = (ACT_W + 1)'(th_o) + (ACT_W + 1)'((1 << FRAC_BITS) + 1);
    sf   = (ACT_W + 1)'(th_f) + (ACT_W + 1)'((1 << FRAC_BITS) + 1);
    gi_d = si[GATE_W:1];
    go_d = so[GATE_W:1];
    gf_d = sf[GATE_W:1];
  end

  assign ig_prod = $signed({1'b0, gi3_q}) * gc3_q;

  // Cell update, with the cell value of the item in stage 5 forwarded on an index match.
  always_comb begin
    if (load4_q) begin
      c_old = init4_q;
    end else if (v5_q && (idx5_q[ADDR_W-1:0] == idx4_q[ADDR_W-1:0])) begin
      c_old = c5_q;
    end else begin
      c_old = rd_q;
    end
    cf_prod = $signed({1'b0, cf4_q}) * c_old;
    acc     = 44'(cf_prod) + (44'(ig4_q) <<< 12);
    acc_rnd = acc + (44'sd1 <<< (FRAC_BITS + 11));
    acc_sh  = 20'(acc_rnd >>> (FRAC_BITS + 12));
    if (acc_sh > 20'sd32767) begin
      c5_d = 16'sh7fff;
    end else if (acc_sh < -20'sd32768) begin
      c5_d = -16'sh8000;
    end else begin
      c5_d = 16'(acc_sh);
    end
  end

  always_comb begin
    hp     = $signed({1'b0, go5_q}) * th_c5;
    hp_rnd = hp + (2*ACT_W)'(1 << (FRAC_BITS - 1));
    h6_d   = HID_W'(hp_rnd >>> FRAC_BITS);
  end

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && v4_q;
      mem_waddr = idx4_q[ADDR_W-1:0];
      mem_wdata = c5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_q <= cell_mem_q[idx3_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx1_q  <= element_index_i;
      x1_q[0] <= x_input_gate_i;
      x1_q[1] <= x_output_gate_i;
      x1_q[2] <= x_forget_gate_i;
      x1_q[3] <= x_cell_gate_i;
      h1_q[0] <= h_input_gate_i;
      h1_q[1] <= h_output_gate_i;
      h1_q[2] <= h_forget_gate_i;
      h1_q[3] <= h_cell_gate_i;
      cont1_q <= cont_d;
      load1_q <= load_initial_i;
      init1_q <= initial_cell_i;

      idx2_q  <= idx1_q;
      g2_q    <= g2_d;
      cont2_q <= cont1_q;
      load2_q <= load1_q;
      init2_q <= init1_q;

      idx3_q  <= idx2_q;
      gi3_q   <= gi_d;
      go3_q   <= go_d;
      gf3_q   <= gf_d;
      gc3_q   <= th_c;
      cont3_q <= cont2_q;
      load3_q <= load2_q;
      init3_q <= init2_q;

      idx4_q  <= idx3_q;
      cf4_q   <= cont3_q * gf3_q;
      ig4_q   <= ig_prod;
      go4_q   <= go3_q;
      load4_q <= load3_q;
      init4_q <= init3_q;

      idx5_q  <= idx4_q;
      c5_q    <= c5_d;
      go5_q   <= go4_q;

      idx6_q  <= idx5_q;
      c6_q    <= c5_q;
      h6_q    <= h6_d;
    end
    if (!sk_v_q && v6_q && !out_ready_i) begin
      idx_sk_q <= idx6_q;
      c_sk_q   <= c6_q;
      h_sk_q   <= h6_q;
    end
  end

  assign out_valid_o  = sk_v_q || v6_q;
  assign out_index_o  = sk_v_q ? idx_sk_q : idx6_q;
  assign new_cell_o   = sk_v_q ? c_sk_q : c6_q;
  assign new_hidden_o = sk_v_q ? h_sk_q : h6_q;

  `LCSU_ASSERT(a_no_accept_in_clear, !(clr_busy_q && in_ready_o), "input taken while clearing")
  `LCSU_ASSERT(a_no_update_in_clear, !(clr_busy_q && (v4_q || v6_q)), "item in flight while clearing")
  `LCSU_ASSERT_NEXT(a_accept_enters, in_fire, v1_q, "accepted item lost at first stage")
  `LCSU_ASSERT_NEXT(a_skid_drains, sk_v_q && out_ready_i, !sk_v_q, "skid register not released")

endmodule

`default_nettype wire

/* rtl/core/lcsu_tanh.sv */
// ----------------------------------------------------------------------------
// LSTM cell state update unit: tanh lookup
// Maps a signed Q3.12 value to tanh by a magnitude table and restores the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsu_tanh (
  input  logic signed [lcsu_pkg::DATA_W-1:0] x_i,
  output logic signed [lcsu_pkg::ACT_W-1:0]  y_o
);
  import lcsu_pkg::*;

  logic [DATA_W-1:0]       mag;
  logic [DATA_W-1:0]       idx_full;
  logic [LUT_IDX_W-1:0]    idx;
  logic signed [ACT_W-1:0] pos;

  always_comb begin
    mag      = x_i[DATA_W-1] ? DATA_W'(-x_i) : DATA_W'(x_i);
    idx_full = mag >> LUT_SHIFT;
    if (idx_full >= DATA_W'(TANH_TABLE_ENTRIES)) begin
      idx = '1;
    end else begin
      idx = idx_full[LUT_IDX_W-1:0];
    end
    pos = signed'(ACT_W'(TANH_LUT[idx]));
    y_o = x_i[DATA_W-1] ? -pos : pos;
  end

endmodule

`default_nettype wire
